// ===== design/ec_meter_range_switch_calibration_unit_defines.svh =====
// Assertion helpers shared by the RTL.
`ifndef EC_METER_RANGE_SWITCH_CALIBRATION_UNIT_DEFINES_SVH
`define EC_METER_RANGE_SWITCH_CALIBRATION_UNIT_DEFINES_SVH

// Same-cycle implication, muted while reset is low.
`define ECMRSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is low.
`define ECMRSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ecmrsc_pkg.sv =====
package ecmrsc_pkg;

    // shared divider geometry
    localparam int DIVD_W = 40;
    localparam int DIVS_W = 28;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

    // range hysteresis on raw * K (K is Q2.14)
    localparam logic [31:0] RANGE_UP_TH = 32'd40960000;   // 2500 << 14
    localparam logic [31:0] RANGE_DN_TH = 32'd32768000;   // 2000 << 14

    // calibration buffers
    localparam logic [13:0] REF_LOW  = 14'd1413;
    localparam logic [13:0] REF_HIGH = 14'd12880;
    localparam logic [15:0] BUF_LOW_MIN  = 16'd1900;
    localparam logic [15:0] BUF_LOW_MAX  = 16'd2900;
    localparam logic [15:0] BUF_HIGH_MIN = 16'd10000;
    localparam logic [15:0] BUF_HIGH_MAX = 16'd22000;

    // accepted K window, Q2.14, and the power-up K
    localparam logic [15:0] K_MIN   = 16'd8193;
    localparam logic [15:0] K_MAX   = 16'd24575;
    localparam logic [15:0] K_RESET = 16'd16384;

    // temperature factor, Q.20; 25 degrees in sixteenths
    localparam logic signed [25:0] F_ONE    = 26'sd1048576;
    localparam logic signed [12:0] T_REF_16 = 13'sd400;

    localparam logic [15:0] GAIN_RESET = 16'd1561;
    localparam logic [11:0] COEF_RESET = 12'd1212;

    // configuration register indexes
    localparam logic [1:0] REG_CELL_GAIN = 2'd0;
    localparam logic [1:0] REG_TEMP_COEF = 2'd1;
    localparam logic [1:0] REG_K_LOW     = 2'd2;
    localparam logic [1:0] REG_K_HIGH    = 2'd3;

    // op kinds
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // commands
    localparam logic [1:0] CMD_UNKNOWN = 2'd0;
    localparam logic [1:0] CMD_ENTER   = 2'd1;
    localparam logic [1:0] CMD_CAL     = 2'd2;
    localparam logic [1:0] CMD_EXIT    = 2'd3;

    // result status
    localparam logic [3:0] ST_NONE        = 4'd0;
    localparam logic [3:0] ST_ENTERED     = 4'd1;
    localparam logic [3:0] ST_CMD_ERR     = 4'd2;
    localparam logic [3:0] ST_BUF_UNKNOWN = 4'd3;
    localparam logic [3:0] ST_K_RANGE     = 4'd4;
    localparam logic [3:0] ST_LOW_OK      = 4'd5;
    localparam logic [3:0] ST_HIGH_OK     = 4'd6;
    localparam logic [3:0] ST_SAVE_LOW    = 4'd7;
    localparam logic [3:0] ST_SAVE_HIGH   = 4'd8;
    localparam logic [3:0] ST_EXIT_FAIL   = 4'd9;
    localparam logic [3:0] ST_EXIT_NONE   = 4'd10;

endpackage

// ===== design/ecmrsc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ecmrsc_div import ecmrsc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIVS_W:0]   r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dsr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W+1:0] diff;
    logic              ge;

    assign trial = {r_rem[DIVS_W-1:0], r_quo[DIVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_dsr};
    assign ge    = ~diff[DIVS_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_quo  <= i_req.dividend;
            r_rem  <= '0;
            r_dsr  <= i_req.divisor;
            r_cnt  <= CNT_W'(DIVD_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_rem  <= ge ? diff[DIVS_W:0] : trial;
            r_quo  <= {r_quo[DIVD_W-2:0], ge};
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.busy     = (r_cnt != '0);
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== design/ec_meter_range_switch_calibration_unit.sv =====
// Channel   Dir  Handshake            Payload
// s (item)  in   i_s_tvalid/o_s_tready tdata: voltage_mv, temperature, command; tuser: op
// m (res)   out  o_m_tvalid/i_m_tready tdata: ec_value, high_range, status, k_out
// cfg       in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A measure item steps through S_MUL_VG, S_MUL_TF, S_DISP, S_RANGE, S_NUM, S_DIV and S_OUT,
// skipping S_DIV when the temperature factor is not positive; a calibrate item that divides
// takes S_KMUL and the 40-step restoring divider after S_DISP. Other commands go from S_DISP to S_OUT.
// One item at a time: o_s_tready is high only when the sequencer is idle. The result
// sits in an output register, so the next item is taken while it waits for i_m_tready.
// Reset is synchronous, active low; the config port is always ready.
`include "ec_meter_range_switch_calibration_unit_defines.svh"

module ec_meter_range_switch_calibration_unit import ecmrsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // [11:0] voltage_mv, [23:12] temperature, [25:24] command
    input  logic        i_s_tuser,    // [0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,    // [15:0] ec_value, [16] high_range, [20:17] status,
                                      // [36:21] k_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL_VG = 4'd1;
    localparam logic [3:0] S_MUL_TF = 4'd2;
    localparam logic [3:0] S_DISP   = 4'd3;
    localparam logic [3:0] S_RANGE  = 4'd4;
    localparam logic [3:0] S_NUM    = 4'd5;
    localparam logic [3:0] S_KMUL   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]  r_state, n_state;

    logic        r_op;
    logic [11:0] r_v;
    logic [11:0] r_t;
    logic [1:0]  r_cmd;

    logic [15:0] r_gain;
    logic [11:0] r_coef;
    logic [15:0] r_k_low, r_k_high, r_k_act;
    logic        r_hi;
    logic [15:0] r_last_raw;
    logic        r_in_cal, r_cal_done;

    logic [27:0]        r_vg;
    logic signed [25:0] r_f;
    logic [15:0]        r_raw;
    logic               r_buf_hi;
    logic               r_div_meas;

    logic [15:0] r_ec, r_kout;
    logic [3:0]  r_stat;
    logic        r_o_valid;
    logic [39:0] r_o_data;

    // shared multiplier
    logic [23:0] mul_a;
    logic [15:0] mul_b;
    logic [39:0] mul_p;

    logic signed [12:0] t_diff;
    logic [11:0]        t_abs;
    logic [28:0]        raw_sum;
    logic [15:0]        raw_sat;
    logic               buf_low, buf_high;
    logic               f_pos, f_zero;
    logic [37:0]        num;
    logic [15:0]        q_sat;
    logic               k_ok;
    logic               out_load;
    logic               s_acc;
    logic [3:0]         disp_stat;
    logic [15:0]        disp_kout;

    t_div_req div_req;
    t_div_rsp div_rsp;

    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_o_valid;
    assign o_m_tdata   = r_o_data;

    assign t_diff = {r_t[11], r_t} - T_REF_16;
    assign t_abs  = t_diff[12] ? 12'(-t_diff) : t_diff[11:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_VG: begin
                mul_a = {12'd0, r_v};
                mul_b = r_gain;
            end
            S_MUL_TF: begin
                mul_a = {12'd0, t_abs};
                mul_b = {4'd0, r_coef};
            end
            S_RANGE, S_NUM: begin
                mul_a = {8'd0, r_raw};
                mul_b = r_k_act;
            end
            S_KMUL: begin
                mul_a = r_f[23:0];
                mul_b = {2'b00, r_buf_hi ? REF_HIGH : REF_LOW};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign raw_sum = {1'b0, r_vg} + 29'd128;
    assign raw_sat = (|raw_sum[28:24]) ? 16'hFFFF : raw_sum[23:8];

    assign buf_low  = (r_last_raw > BUF_LOW_MIN) && (r_last_raw < BUF_LOW_MAX);
    assign buf_high = (r_last_raw > BUF_HIGH_MIN) && (r_last_raw < BUF_HIGH_MAX);

    assign f_pos  = !r_f[25] && (r_f != '0);
    assign f_zero = (r_f == '0);

    assign num = {mul_p[31:0], 6'd0};

    assign q_sat = (|div_rsp.quotient[DIVD_W-1:16]) ? 16'hFFFF : div_rsp.quotient[15:0];
    assign k_ok  = (div_rsp.quotient >= DIVD_W'(K_MIN)) &&
                   (div_rsp.quotient <= DIVD_W'(K_MAX));

    // status and K decided at dispatch; S_NUM sets K for a measure, a calibrate divide overwrites both
    always_comb begin
        disp_stat = ST_NONE;
        disp_kout = '0;
        if (r_op == OP_COMMAND) begin
            case (r_cmd)
                CMD_UNKNOWN: disp_stat = r_in_cal ? ST_CMD_ERR : ST_NONE;
                CMD_ENTER:   disp_stat = ST_ENTERED;
                CMD_CAL: begin
                    if (r_in_cal) begin
                        if (!buf_low && !buf_high) begin
                            disp_stat = ST_BUF_UNKNOWN;
                        end else if (r_vg == '0 || !f_pos) begin
                            disp_stat = ST_K_RANGE;
                        end
                    end
                end
                CMD_EXIT: begin
                    if (r_in_cal) begin
                        if (!r_cal_done) begin
                            disp_stat = ST_EXIT_FAIL;
                        end else if (buf_low) begin
                            disp_stat = ST_SAVE_LOW;
                            disp_kout = r_k_low;
                        end else if (buf_high) begin
                            disp_stat = ST_SAVE_HIGH;
                            disp_kout = r_k_high;
                        end else begin
                            disp_stat = ST_EXIT_NONE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        div_req = '0;
        if (r_state == S_NUM && f_pos) begin
            div_req.start    = 1'b1;
            div_req.dividend = {2'b00, num} + DIVD_W'(r_f[25:1]);
            div_req.divisor  = {2'b00, r_f};
        end else if (r_state == S_KMUL) begin
            div_req.start    = 1'b1;
            div_req.dividend = {mul_p[37:0], 2'b00} + DIVD_W'(r_vg[27:1]);
            div_req.divisor  = r_vg;
        end
    end

    ecmrsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_load = (r_state == S_OUT) && (!r_o_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (s_acc) n_state = S_MUL_VG;
            S_MUL_VG: n_state = S_MUL_TF;
            S_MUL_TF: n_state = S_DISP;
            S_DISP: begin
                if (r_op == OP_MEASURE) begin
                    n_state = S_RANGE;
                end else if (r_cmd == CMD_CAL && r_in_cal && (buf_low || buf_high) &&
                             r_vg != '0 && f_pos) begin
                    n_state = S_KMUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RANGE:  n_state = S_NUM;
            S_NUM:    n_state = f_pos ? S_DIV : S_OUT;
            S_KMUL:   n_state = S_DIV;
            S_DIV:    if (div_rsp.done) n_state = S_OUT;
            S_OUT:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_gain     <= GAIN_RESET;
            r_coef     <= COEF_RESET;
            r_k_low    <= K_RESET;
            r_k_high   <= K_RESET;
            r_k_act    <= K_RESET;
            r_hi       <= 1'b0;
            r_last_raw <= '0;
            r_in_cal   <= 1'b0;
            r_cal_done <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CELL_GAIN: r_gain   <= i_cfg_data;
                    REG_TEMP_COEF: r_coef   <= i_cfg_data[11:0];
                    REG_K_LOW:     r_k_low  <= {1'b0, i_cfg_data[14:0]};
                    REG_K_HIGH:    r_k_high <= {1'b0, i_cfg_data[14:0]};
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_op  <= i_s_tuser;
                        r_v   <= i_s_tdata[11:0];
                        r_t   <= i_s_tdata[23:12];
                        r_cmd <= i_s_tdata[25:24];
                    end
                end
                S_MUL_VG: r_vg <= mul_p[27:0];
                S_MUL_TF: r_f <= t_diff[12] ? F_ONE - $signed({2'b00, mul_p[23:0]})
                                            : F_ONE + $signed({2'b00, mul_p[23:0]});
                S_DISP: begin
                    r_ec   <= '0;
                    r_kout <= disp_kout;
                    r_stat <= disp_stat;
                    if (r_op == OP_MEASURE) begin
                        r_raw      <= raw_sat;
                        r_last_raw <= raw_sat;
                    end else begin
                        case (r_cmd)
                            CMD_ENTER: begin
                                r_in_cal   <= 1'b1;
                                r_cal_done <= 1'b0;
                            end
                            CMD_CAL: begin
                                if (r_in_cal) begin
                                    r_buf_hi <= !buf_low;
                                    if ((!buf_low && !buf_high) || r_vg == '0 || !f_pos) begin
                                        r_cal_done <= 1'b0;
                                    end
                                end
                            end
                            CMD_EXIT: begin
                                if (r_in_cal) begin
                                    r_in_cal   <= 1'b0;
                                    r_cal_done <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RANGE: begin
                    // hysteresis uses the K that was active before this sample
                    if (mul_p[31:0] > RANGE_UP_TH) begin
                        r_k_act <= r_k_high;
                        r_hi    <= 1'b1;
                    end else if (mul_p[31:0] < RANGE_DN_TH) begin
                        r_k_act <= r_k_low;
                        r_hi    <= 1'b0;
                    end
                end
                S_NUM: begin
                    r_kout     <= r_k_act;
                    r_div_meas <= 1'b1;
                    if (f_zero) begin
                        r_ec <= (num != '0) ? 16'hFFFF : 16'h0000;
                    end
                end
                S_KMUL: r_div_meas <= 1'b0;
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (r_div_meas) begin
                            r_ec <= q_sat;
                        end else begin
                            r_kout <= q_sat;
                            if (k_ok) begin
                                r_cal_done <= 1'b1;
                                if (r_buf_hi) begin
                                    r_k_high <= div_rsp.quotient[15:0];
                                    r_stat   <= ST_HIGH_OK;
                                end else begin
                                    r_k_low <= div_rsp.quotient[15:0];
                                    r_stat  <= ST_LOW_OK;
                                end
                            end else begin
                                r_cal_done <= 1'b0;
                                r_stat     <= ST_K_RANGE;
                            end
                        end
                    end
                end
                default: ;
            endcase

            if (out_load) begin
                r_o_valid <= 1'b1;
                r_o_data  <= {3'd0, r_kout, r_stat, r_hi, r_ec};
            end else if (r_o_valid && i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    `ECMRSC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_acc, !o_s_tready,
        "input taken while an item was still in work")
    `ECMRSC_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV,
        "divider finished outside the divide state")
    `ECMRSC_ASSERT_IMP(a_cal_done_needs_cal, i_clk, i_rst_n, r_cal_done, r_in_cal,
        "calibration marked done outside calibration")
    `ECMRSC_ASSERT_IMP(a_start_when_free, i_clk, i_rst_n, div_req.start, !div_rsp.busy,
        "divider restarted while busy")

endmodule

// ===== tb/ec_reading_checker.sv =====
`timescale 1ns / 100ps

module ec_reading_checker import ecmrsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,    // [11:0] voltage_mv, [23:12] temperature, [25:24] command
    input  logic        i_s_tuser,    // [0] op
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,    // [15:0] ec_value, [16] high_range, [20:17] status,
                                      // [36:21] k_out
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);

    typedef struct packed {
        logic [15:0] ec_value;
        logic        high_range;
        logic [3:0]  status;
        logic [15:0] k_out;
    } t_reading;

    typedef enum logic [1:0] {SOLN_NONE, SOLN_LOW, SOLN_HIGH} t_solution;

    // raw * K thresholds of the range switch, K in Q2.14
    localparam logic [63:0] SWITCH_UP_AT   = 64'd2500 << 14;
    localparam logic [63:0] SWITCH_DOWN_AT = 64'd2000 << 14;
    localparam logic [63:0] LOW_SOLN_EC    = 64'd1413;
    localparam logic [63:0] HIGH_SOLN_EC   = 64'd12880;
    localparam logic [63:0] K_LOWEST       = 64'd8193;
    localparam logic [63:0] K_HIGHEST      = 64'd24575;

    logic [15:0] cell_gain;
    logic [11:0] temp_coef;
    logic [15:0] k_low, k_high, k_active, last_raw_ec;
    logic        high_range, in_calibration, calibration_done;
    t_reading    expected_readings[$];
    int          fails = 0;

    function automatic logic [15:0] sat16(input logic [63:0] v);
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic t_solution solution_of(input logic [15:0] raw);
        if (raw > 16'd1900 && raw < 16'd2900) return SOLN_LOW;
        if (raw > 16'd10000 && raw < 16'd22000) return SOLN_HIGH;
        return SOLN_NONE;
    endfunction

    task automatic predict_reading(input logic op, input logic [11:0] mv,
                                   input logic signed [11:0] temp, input logic [1:0] cmd);
        t_reading    r;
        int          factor;
        int          t16;
        int          coef;
        logic [63:0] prod, num, den, kq, buffer_ec;
        logic [15:0] raw;
        t_solution   soln;
        r = '0;
        t16 = temp;
        coef = temp_coef;
        // Q.20 factor 1 + coef * (T - 25 degrees), exact
        factor = 1048576 + coef * (t16 - 400);
        if (op == OP_MEASURE) begin
            raw = sat16((64'(mv) * 64'(cell_gain) + 64'd128) >> 8);
            last_raw_ec = raw;
            // old K picks the range, the new one scales this reading
            prod = 64'(raw) * 64'(k_active);
            if (prod > SWITCH_UP_AT) begin
                k_active = k_high;
                high_range = 1'b1;
            end else if (prod < SWITCH_DOWN_AT) begin
                k_active = k_low;
                high_range = 1'b0;
            end
            num = 64'(raw) * 64'(k_active) * 64'd64;
            if (factor > 0) begin
                r.ec_value = sat16((num + 64'(factor / 2)) / 64'(factor));
            end else if (factor == 0) begin
                r.ec_value = (num != 64'd0) ? 16'hFFFF : 16'h0000;
            end
            r.k_out = k_active;
        end else begin
            case (cmd)
                CMD_UNKNOWN: begin
                    r.status = in_calibration ? ST_CMD_ERR : ST_NONE;
                end
                CMD_ENTER: begin
                    in_calibration = 1'b1;
                    calibration_done = 1'b0;
                    r.status = ST_ENTERED;
                end
                CMD_CAL: begin
                    if (in_calibration) begin
                        soln = solution_of(last_raw_ec);
                        if (soln == SOLN_NONE) begin
                            r.status = ST_BUF_UNKNOWN;
                            calibration_done = 1'b0;
                        end else begin
                            den = 64'(mv) * 64'(cell_gain);
                            buffer_ec = (soln == SOLN_LOW) ? LOW_SOLN_EC : HIGH_SOLN_EC;
                            kq = 64'd0;
                            if (den != 64'd0 && factor > 0) begin
                                kq = (buffer_ec * 64'(factor) * 64'd4 + den / 2) / den;
                            end
                            r.k_out = sat16(kq);
                            if (kq >= K_LOWEST && kq <= K_HIGHEST) begin
                                if (soln == SOLN_LOW) begin
                                    k_low = kq[15:0];
                                    r.status = ST_LOW_OK;
                                end else begin
                                    k_high = kq[15:0];
                                    r.status = ST_HIGH_OK;
                                end
                                calibration_done = 1'b1;
                            end else begin
                                r.status = ST_K_RANGE;
                                calibration_done = 1'b0;
                            end
                        end
                    end
                end
                CMD_EXIT: begin
                    if (in_calibration) begin
                        if (calibration_done) begin
                            // buffer is recognized again from the latest raw value
                            soln = solution_of(last_raw_ec);
                            if (soln == SOLN_LOW) begin
                                r.status = ST_SAVE_LOW;
                                r.k_out = k_low;
                            end else if (soln == SOLN_HIGH) begin
                                r.status = ST_SAVE_HIGH;
                                r.k_out = k_high;
                            end else begin
                                r.status = ST_EXIT_NONE;
                            end
                        end else begin
                            r.status = ST_EXIT_FAIL;
                        end
                        in_calibration = 1'b0;
                        calibration_done = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        r.high_range = high_range;
        expected_readings.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_reading want;
        if (!i_rst_n) begin
            cell_gain = 16'd1561;
            temp_coef = 12'd1212;
            k_low = 16'd16384;
            k_high = 16'd16384;
            k_active = 16'd16384;
            last_raw_ec = 16'd0;
            high_range = 1'b0;
            in_calibration = 1'b0;
            calibration_done = 1'b0;
            expected_readings.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CELL_GAIN: cell_gain = i_cfg_data;
                    REG_TEMP_COEF: temp_coef = i_cfg_data[11:0];
                    REG_K_LOW:     k_low = {1'b0, i_cfg_data[14:0]};
                    REG_K_HIGH:    k_high = {1'b0, i_cfg_data[14:0]};
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_readings.size() == 0) begin
                    fails++;
                    $display("%0t: result beat expected none, got %h", $time, i_m_tdata);
                end else begin
                    want = expected_readings.pop_front();
                    check_field("ec_value", want.ec_value, i_m_tdata[15:0]);
                    check_field("high_range", 16'(want.high_range), 16'(i_m_tdata[16]));
                    check_field("status", 16'(want.status), 16'(i_m_tdata[20:17]));
                    check_field("k_out", want.k_out, i_m_tdata[36:21]);
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_reading(i_s_tuser, i_s_tdata[11:0], i_s_tdata[23:12],
                                i_s_tdata[25:24]);
        end
        o_pending <= expected_readings.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import ecmrsc_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;    // [11:0] voltage_mv, [23:12] temperature, [25:24] command
    logic        i_s_tuser = 1'b0;  // [0] op
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;         // [15:0] ec_value, [16] high_range, [20:17] status,
                                    // [36:21] k_out
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int pending;
    int fail_count;
    int items_sent = 0;
    int cur_gain = 1561;
    int hold_asked = 0;
    int hold_served = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    always #4 i_clk = ~i_clk;

    ec_meter_range_switch_calibration_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ec_reading_checker reading_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [11:0] pick_temp();
        // now and then the whole field, which can drive the factor negative
        if ($urandom_range(0, 6) == 0) return 12'($urandom);
        return 12'($urandom_range(0, 1920) - 320);
    endfunction

    function automatic logic [11:0] jitter(input int mv);
        int v;
        v = mv + $urandom_range(0, 4) - 2;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    task automatic send_item(input logic op, input logic [11:0] mv, input logic [11:0] temp,
                             input logic [1:0] cmd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata = {6'd0, cmd, temp, mv};
        i_s_tuser = op;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // stop offering and wait for every outstanding reading
    task automatic settle();
        i_s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        i_cfg_index = index;
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [15:0] gain, input logic [15:0] coef,
                             input logic [15:0] klo, input logic [15:0] khi);
        write_reg(REG_CELL_GAIN, gain);
        write_reg(REG_TEMP_COEF, coef);
        write_reg(REG_K_LOW, klo);
        write_reg(REG_K_HIGH, khi);
        i_cfg_valid = 1'b0;
        cur_gain = gain;
    endtask

    // mostly enter, measure a buffer solution, calibrate, then mostly exit
    task automatic calibration_run();
        int          target;
        int          mv;
        logic [11:0] t;
        target = $urandom_range(0, 1) ? $urandom_range(9500, 22500) : $urandom_range(1800, 3000);
        mv = (target * 256 + cur_gain / 2) / cur_gain;
        if (mv > 4095) mv = 4095;
        t = pick_temp();
        if ($urandom_range(0, 9) != 0)
            send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_ENTER);
        repeat ($urandom_range(1, 3)) send_item(OP_MEASURE, jitter(mv), t, 2'($urandom));
        send_item(OP_COMMAND, jitter(mv), t, CMD_CAL);
        if ($urandom_range(0, 4) == 0)
            send_item(OP_MEASURE, 12'($urandom), pick_temp(), 2'($urandom));
        send_item(OP_COMMAND, 12'($urandom), pick_temp(),
                  ($urandom_range(0, 7) == 0) ? CMD_UNKNOWN : CMD_EXIT);
    endtask

    task automatic random_phase(input int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if ($urandom_range(0, 9) < 7)
                calibration_run();
            else
                send_item(1'($urandom), 12'($urandom), pick_temp(), 2'($urandom));
        end
    endtask

    initial begin : result_sink
        int w;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            w = pick_gap();
            if (w > 0) begin
                i_m_tready = 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ec_meter_range_switch_calibration_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int          phase;
        logic [15:0] gain, coef, klo, khi;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // power-up settings: extremes of the fields, range switch, every command path
        send_item(OP_MEASURE, 12'd0, 12'd400, CMD_UNKNOWN);
        send_item(OP_MEASURE, 12'd4095, 12'h7FF, CMD_EXIT);
        send_item(OP_MEASURE, 12'd4095, 12'h800, CMD_CAL);      // negative factor
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_UNKNOWN);
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_CAL);
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_EXIT);
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_ENTER);
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_UNKNOWN);
        send_item(OP_COMMAND, 12'd328, 12'd400, CMD_CAL);       // raw not a buffer
        send_item(OP_MEASURE, 12'd328, 12'd400, CMD_ENTER);     // raw 2000, at the down edge
        send_item(OP_COMMAND, 12'd328, 12'd400, CMD_CAL);
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_EXIT);
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_ENTER);
        send_item(OP_MEASURE, 12'd2460, 12'd400, CMD_UNKNOWN);
        send_item(OP_COMMAND, 12'd0, 12'd400, CMD_CAL);         // zero voltage
        send_item(OP_COMMAND, 12'd2460, 12'h800, CMD_CAL);      // factor below zero
        send_item(OP_COMMAND, 12'd2460, 12'd400, CMD_CAL);
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_ENTER);  // restart clears calibration done
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_EXIT);
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_ENTER);
        send_item(OP_MEASURE, 12'd328, 12'd400, CMD_UNKNOWN);
        send_item(OP_COMMAND, 12'd328, 12'd400, CMD_CAL);
        send_item(OP_MEASURE, 12'd4095, 12'd400, CMD_UNKNOWN); // buffer lost before exit
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_EXIT);
        settle();

        // coef 1024 at -39 degrees makes the factor exactly zero
        configure(GAIN_RESET, 16'd1024, K_MIN, K_MAX);
        send_item(OP_MEASURE, 12'd328, 12'(-624), CMD_UNKNOWN);
        send_item(OP_MEASURE, 12'd0, 12'(-624), CMD_UNKNOWN);
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_ENTER);
        send_item(OP_MEASURE, 12'd328, 12'd400, CMD_UNKNOWN);
        send_item(OP_COMMAND, 12'd328, 12'(-624), CMD_CAL);
        send_item(OP_COMMAND, 12'($urandom), pick_temp(), CMD_EXIT);
        settle();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    gain = GAIN_RESET;
                    coef = 16'(COEF_RESET);
                    klo = K_RESET;
                    khi = K_RESET;
                end
                1: begin
                    gain = 16'hFFFF;
                    coef = 16'd4095;
                    klo = K_MAX;
                    khi = K_MIN;
                end
                2: begin
                    gain = 16'd1;
                    coef = 16'd0;
                    klo = K_MIN;
                    khi = K_MAX;
                end
                default: begin
                    gain = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                       : 16'($urandom_range(400, 6000));
                    coef = 16'($urandom_range(0, 4095));
                    klo = 16'($urandom_range(K_MIN, K_MAX));
                    khi = 16'($urandom_range(K_MIN, K_MAX));
                end
            endcase
            configure(gain, coef, klo, khi);
            if (phase == 0) begin
                calm = 1'b1;
                random_phase(40);
                calm = 1'b0;
                random_phase(40);
            end else begin
                // result side stalls long while items keep coming
                if (phase == 1 || phase == 4) hold_asked++;
                random_phase((phase == 2) ? 60 : 80);
            end
            settle();
        end

        repeat (60) @(negedge i_clk);
        if (fail_count == 0)
            $display("ec_meter_range_switch_calibration_unit verification clean");
        else
            $display("ec_meter_range_switch_calibration_unit verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ecmrsc_pkg.sv
design/ecmrsc_div.sv
design/ec_meter_range_switch_calibration_unit.sv
tb/ec_reading_checker.sv
tb/testbench.sv
